[hw/rtl/dcbemf_pkg.sv]
// shared constants, types, microprogram and saturation helpers of the back-emf speed estimator
package dcbemf_pkg;

    localparam int ADC_BITS_DEF  = 12;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DUTY_BITS     = 16;
    localparam int DUTY_HALF     = 32768;
    localparam int DATA_W        = 32;
    localparam int REG_W         = 31;
    localparam int NUM_REGS      = 7;
    localparam int REG_IDX_W     = 3;
    localparam int ACC_W         = 35;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int STEP_W        = 5;

    // configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_LINK_VOLT_SCALE    = 3'd0,
        REG_CURRENT_SCALE      = 3'd1,
        REG_WINDING_RESISTANCE = 3'd2,
        REG_INDUCTANCE_TERM    = 3'd3,
        REG_EMF_UNIT_SCALE     = 3'd4,
        REG_RPM_PER_EMF        = 3'd5,
        REG_WHEEL_PER_MOTOR    = 3'd6
    } reg_idx_t;

    localparam logic [NUM_REGS-1:0][REG_W-1:0] CFG_RESET = {
        31'd65536,  // wheel_per_motor
        31'd65536,  // rpm_per_emf
        31'd65536,  // emf_unit_scale
        31'd0,      // inductance_term
        31'd0,      // winding_resistance
        31'd65536,  // current_scale
        31'd65536   // link_volt_scale
    };

    typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_bank_t;

    // sequencer operation of one step
    typedef enum logic [1:0] {
        SEQ_NEXT    = 2'd0,
        SEQ_WAIT_IN = 2'd1,
        SEQ_COMMIT  = 2'd2,
        SEQ_JUMP    = 2'd3
    } seq_t;

    typedef enum logic [2:0] {
        A_LINK_VOLT_SCALE = 3'd0,
        A_CURRENT_SCALE   = 3'd1,
        A_WINDING_RES     = 3'd2,
        A_INDUCTANCE      = 3'd3,
        A_EMF_UNIT_SCALE  = 3'd4,
        A_RPM_PER_EMF     = 3'd5,
        A_WHEEL_PER_MOTOR = 3'd6,
        A_VDC             = 3'd7
    } a_sel_t;

    typedef enum logic [2:0] {
        B_LINK = 3'd0,
        B_CADC = 3'd1,
        B_DUTY = 3'd2,
        B_ISUM = 3'd3,
        B_IDIF = 3'd4,
        B_ESUM = 3'd5,
        B_EMF  = 3'd6,
        B_RPM  = 3'd7
    } b_sel_t;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_DUTY = 2'd1,
        SH_FRAC = 2'd2
    } shift_t;

    typedef enum logic [2:0] {
        WB_NONE  = 3'd0,
        WB_VDC   = 3'd1,
        WB_CUR   = 3'd2,
        WB_VOLT  = 3'd3,
        WB_TMP   = 3'd4,
        WB_EMF   = 3'd5,
        WB_RPM   = 3'd6,
        WB_WHEEL = 3'd7
    } wb_t;

    typedef enum logic [2:0] {
        ALU_NONE = 3'd0,
        ALU_ISUM = 3'd1,
        ALU_IDIF = 3'd2,
        ALU_VSUM = 3'd3,
        ALU_SUBT = 3'd4,
        ALU_SUBE = 3'd5
    } alu_t;

    typedef struct packed {
        seq_t              seq;
        logic [STEP_W-1:0] target;
        logic              mul_en;
        a_sel_t            a_sel;
        b_sel_t            b_sel;
        shift_t            shift;
        wb_t               wb;
        alu_t              alu;
    } ucode_t;

    localparam logic [STEP_W-1:0] STEP_START = '0;

    function automatic ucode_t mk(
        input seq_t   seq,
        input logic   mul_en,
        input a_sel_t a_sel,
        input b_sel_t b_sel,
        input shift_t shift,
        input wb_t    wb,
        input alu_t   alu
    );
        ucode_t w;
        w.seq    = seq;
        w.target = STEP_START;
        w.mul_en = mul_en;
        w.a_sel  = a_sel;
        w.b_sel  = b_sel;
        w.shift  = shift;
        w.wb     = wb;
        w.alu    = alu;
        return w;
    endfunction

    // microprogram rom
    function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            5'd0:  w = mk(SEQ_WAIT_IN, 1'b0, A_VDC, B_LINK, SH_NONE, WB_NONE, ALU_NONE);
            5'd1:  w = mk(SEQ_NEXT, 1'b1, A_LINK_VOLT_SCALE, B_LINK, SH_NONE, WB_NONE,
                          ALU_NONE);
            5'd2:  w = mk(SEQ_NEXT, 1'b1, A_CURRENT_SCALE, B_CADC, SH_NONE, WB_VDC,
                          ALU_NONE);
            5'd3:  w = mk(SEQ_NEXT, 1'b1, A_VDC, B_DUTY, SH_NONE, WB_CUR, ALU_NONE);
            5'd4:  w = mk(SEQ_NEXT, 1'b0, A_VDC, B_LINK, SH_DUTY, WB_VOLT, ALU_ISUM);
            5'd5:  w = mk(SEQ_NEXT, 1'b1, A_WINDING_RES, B_ISUM, SH_NONE, WB_NONE,
                          ALU_IDIF);
            5'd6:  w = mk(SEQ_NEXT, 1'b1, A_INDUCTANCE, B_IDIF, SH_FRAC, WB_TMP, ALU_VSUM);
            5'd7:  w = mk(SEQ_NEXT, 1'b0, A_VDC, B_LINK, SH_FRAC, WB_TMP, ALU_SUBT);
            5'd8:  w = mk(SEQ_NEXT, 1'b0, A_VDC, B_LINK, SH_NONE, WB_NONE, ALU_SUBT);
            5'd9:  w = mk(SEQ_NEXT, 1'b0, A_VDC, B_LINK, SH_NONE, WB_NONE, ALU_SUBE);
            5'd10: w = mk(SEQ_NEXT, 1'b1, A_EMF_UNIT_SCALE, B_ESUM, SH_NONE, WB_NONE,
                          ALU_NONE);
            5'd11: w = mk(SEQ_NEXT, 1'b0, A_VDC, B_LINK, SH_FRAC, WB_EMF, ALU_NONE);
            5'd12: w = mk(SEQ_NEXT, 1'b1, A_RPM_PER_EMF, B_EMF, SH_NONE, WB_NONE, ALU_NONE);
            5'd13: w = mk(SEQ_NEXT, 1'b0, A_VDC, B_LINK, SH_FRAC, WB_RPM, ALU_NONE);
            5'd14: w = mk(SEQ_NEXT, 1'b1, A_WHEEL_PER_MOTOR, B_RPM, SH_NONE, WB_NONE,
                          ALU_NONE);
            5'd15: w = mk(SEQ_NEXT, 1'b0, A_VDC, B_LINK, SH_FRAC, WB_WHEEL, ALU_NONE);
            5'd16: w = mk(SEQ_COMMIT, 1'b0, A_VDC, B_LINK, SH_NONE, WB_NONE, ALU_NONE);
            default: w = mk(SEQ_JUMP, 1'b0, A_VDC, B_LINK, SH_NONE, WB_NONE, ALU_NONE);
        endcase
        return w;
    endfunction

    // clamp a full product to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat_prod(input logic signed [PROD_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if ((&x[PROD_W-1:DATA_W-1]) || !(|x[PROD_W-1:DATA_W-1]))
            r = x[DATA_W-1:0];
        else if (x[PROD_W-1])
            r = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r = {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

    // clamp an accumulator value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if ((&x[ACC_W-1:DATA_W-1]) || !(|x[ACC_W-1:DATA_W-1]))
            r = x[DATA_W-1:0];
        else if (x[ACC_W-1])
            r = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r = {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] ext_acc(input logic signed [DATA_W-1:0] x);
        return {{(ACC_W-DATA_W){x[DATA_W-1]}}, x};
    endfunction

endpackage

[hw/rtl/dcbemf_intf.sv]
// sample, result and configuration channel interfaces
interface dcbemf_in_if #(
    parameter int ADC_BITS = dcbemf_pkg::ADC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] link_adc;
    logic [15:0]         pwm_duty;
    logic [ADC_BITS-1:0] current_adc;

    modport source (output valid, output link_adc, output pwm_duty, output current_adc,
                    input ready);
    modport sink (input valid, input link_adc, input pwm_duty, input current_adc,
                  output ready);
endinterface

interface dcbemf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] motor_voltage;
    logic signed [31:0] motor_current;
    logic signed [31:0] back_emf;
    logic signed [31:0] motor_rpm;
    logic signed [31:0] wheel_rpm;

    modport source (output valid, output motor_voltage, output motor_current,
                    output back_emf, output motor_rpm, output wheel_rpm, input ready);
    modport sink (input valid, input motor_voltage, input motor_current,
                  input back_emf, input motor_rpm, input wheel_rpm, output ready);
endinterface

interface dcbemf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [30:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/dcbemf_datapath.sv]
// shared multiplier, adder and working registers driven by the control word
module dcbemf_datapath #(
    parameter int ADC_BITS  = dcbemf_pkg::ADC_BITS_DEF,
    parameter int FRAC_BITS = dcbemf_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dcbemf_pkg::ucode_t                  ctrl,
    input  logic                                load,
    input  logic                                commit,
    input  logic [ADC_BITS-1:0]                 link_adc,
    input  logic [15:0]                         pwm_duty,
    input  logic [ADC_BITS-1:0]                 current_adc,
    input  dcbemf_pkg::cfg_bank_t               cfg_regs,
    output logic signed [dcbemf_pkg::DATA_W-1:0] motor_voltage,
    output logic signed [dcbemf_pkg::DATA_W-1:0] motor_current,
    output logic signed [dcbemf_pkg::DATA_W-1:0] back_emf,
    output logic signed [dcbemf_pkg::DATA_W-1:0] motor_rpm,
    output logic signed [dcbemf_pkg::DATA_W-1:0] wheel_rpm
);

    localparam int DW = dcbemf_pkg::DATA_W;
    localparam int AW = dcbemf_pkg::ACC_W;
    localparam int PW = dcbemf_pkg::PROD_W;
    localparam int DUTY_W = dcbemf_pkg::DUTY_BITS + 1;

    logic [ADC_BITS-1:0]      link_reg;
    logic [ADC_BITS-1:0]      cadc_reg;
    logic signed [DUTY_W-1:0] duty_reg;
    logic signed [DW-1:0]     vdc_reg;
    logic signed [DW-1:0]     cur_reg;
    logic signed [DW-1:0]     volt_reg;
    logic signed [DW-1:0]     isum_reg;
    logic signed [DW-1:0]     idif_reg;
    logic signed [DW-1:0]     tmp_reg;
    logic signed [DW-1:0]     emf_reg;
    logic signed [DW-1:0]     rpm_reg;
    logic signed [DW-1:0]     wheel_reg;
    logic signed [AW-1:0]     acc_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [DW-1:0]     prev_cur_reg;
    logic signed [DW-1:0]     prev_volt_reg;
    logic signed [DW-1:0]     prev_emf_reg;
    logic signed [DW-1:0]     rpm_out_reg;
    logic signed [DW-1:0]     wheel_out_reg;

    logic signed [DW-1:0]     a_op;
    logic signed [DW-1:0]     b_op;
    logic signed [PW-1:0]     prod_next;
    logic signed [PW-1:0]     shifted;
    logic signed [DW-1:0]     wb_val;
    logic signed [AW-1:0]     alu_x;
    logic signed [AW-1:0]     alu_y;
    logic                     alu_sub;
    logic signed [AW-1:0]     alu_res;
    logic signed [DUTY_W-1:0] duty_next;

    assign duty_next = $signed({1'b0, pwm_duty}) - DUTY_W'(dcbemf_pkg::DUTY_HALF);

    // multiplier operand selection
    always_comb
    begin
        unique case (ctrl.a_sel)
            dcbemf_pkg::A_LINK_VOLT_SCALE:
                a_op = $signed({1'b0, cfg_regs[dcbemf_pkg::REG_LINK_VOLT_SCALE]});
            dcbemf_pkg::A_CURRENT_SCALE:
                a_op = $signed({1'b0, cfg_regs[dcbemf_pkg::REG_CURRENT_SCALE]});
            dcbemf_pkg::A_WINDING_RES:
                a_op = $signed({1'b0, cfg_regs[dcbemf_pkg::REG_WINDING_RESISTANCE]});
            dcbemf_pkg::A_INDUCTANCE:
                a_op = $signed({1'b0, cfg_regs[dcbemf_pkg::REG_INDUCTANCE_TERM]});
            dcbemf_pkg::A_EMF_UNIT_SCALE:
                a_op = $signed({1'b0, cfg_regs[dcbemf_pkg::REG_EMF_UNIT_SCALE]});
            dcbemf_pkg::A_RPM_PER_EMF:
                a_op = $signed({1'b0, cfg_regs[dcbemf_pkg::REG_RPM_PER_EMF]});
            dcbemf_pkg::A_WHEEL_PER_MOTOR:
                a_op = $signed({1'b0, cfg_regs[dcbemf_pkg::REG_WHEEL_PER_MOTOR]});
            default:
                a_op = vdc_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.b_sel)
            dcbemf_pkg::B_LINK: b_op = $signed({{(DW-ADC_BITS){1'b0}}, link_reg});
            dcbemf_pkg::B_CADC: b_op = $signed({{(DW-ADC_BITS){1'b0}}, cadc_reg});
            dcbemf_pkg::B_DUTY: b_op = {{(DW-DUTY_W){duty_reg[DUTY_W-1]}}, duty_reg};
            dcbemf_pkg::B_ISUM: b_op = isum_reg;
            dcbemf_pkg::B_IDIF: b_op = idif_reg;
            dcbemf_pkg::B_ESUM: b_op = acc_reg[DW-1:0];
            dcbemf_pkg::B_EMF:  b_op = emf_reg;
            default:            b_op = rpm_reg;
        endcase
    end

    assign prod_next = a_op * b_op;

    // floor shift of the registered product, then clamp
    always_comb
    begin
        case (ctrl.shift)
            dcbemf_pkg::SH_DUTY: shifted = prod_reg >>> dcbemf_pkg::DUTY_BITS;
            dcbemf_pkg::SH_FRAC: shifted = prod_reg >>> FRAC_BITS;
            default:             shifted = prod_reg;
        endcase
    end

    assign wb_val = dcbemf_pkg::sat_prod(shifted);

    // add / subtract unit
    always_comb
    begin
        alu_x   = acc_reg;
        alu_y   = dcbemf_pkg::ext_acc(tmp_reg);
        alu_sub = 1'b1;
        case (ctrl.alu)
            dcbemf_pkg::ALU_ISUM:
            begin
                alu_x   = dcbemf_pkg::ext_acc(cur_reg);
                alu_y   = dcbemf_pkg::ext_acc(prev_cur_reg);
                alu_sub = 1'b0;
            end
            dcbemf_pkg::ALU_IDIF:
            begin
                alu_x = dcbemf_pkg::ext_acc(cur_reg);
                alu_y = dcbemf_pkg::ext_acc(prev_cur_reg);
            end
            dcbemf_pkg::ALU_VSUM:
            begin
                alu_x   = dcbemf_pkg::ext_acc(volt_reg);
                alu_y   = dcbemf_pkg::ext_acc(prev_volt_reg);
                alu_sub = 1'b0;
            end
            dcbemf_pkg::ALU_SUBE:
            begin
                alu_y = dcbemf_pkg::ext_acc(prev_emf_reg);
            end
            default:
            begin
                alu_y = dcbemf_pkg::ext_acc(tmp_reg);
            end
        endcase
        alu_res = alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            link_reg <= link_adc;
            cadc_reg <= current_adc;
            duty_reg <= duty_next;
        end
        if (ctrl.mul_en)
            prod_reg <= prod_next;
        case (ctrl.wb)
            dcbemf_pkg::WB_VDC:   vdc_reg   <= wb_val;
            dcbemf_pkg::WB_CUR:   cur_reg   <= wb_val;
            dcbemf_pkg::WB_VOLT:  volt_reg  <= wb_val;
            dcbemf_pkg::WB_TMP:   tmp_reg   <= wb_val;
            dcbemf_pkg::WB_EMF:   emf_reg   <= wb_val;
            dcbemf_pkg::WB_RPM:   rpm_reg   <= wb_val;
            dcbemf_pkg::WB_WHEEL: wheel_reg <= wb_val;
            default: ;
        endcase
        case (ctrl.alu)
            dcbemf_pkg::ALU_ISUM: isum_reg <= dcbemf_pkg::sat_acc(alu_res);
            dcbemf_pkg::ALU_IDIF: idif_reg <= dcbemf_pkg::sat_acc(alu_res);
            dcbemf_pkg::ALU_VSUM,
            dcbemf_pkg::ALU_SUBE:
                acc_reg <= dcbemf_pkg::ext_acc(dcbemf_pkg::sat_acc(alu_res));
            dcbemf_pkg::ALU_SUBT: acc_reg <= alu_res;
            default: ;
        endcase
        if (commit)
        begin
            rpm_out_reg   <= rpm_reg;
            wheel_out_reg <= wheel_reg;
        end
    end

    // history, doubles as the held result fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cur_reg  <= '0;
            prev_volt_reg <= '0;
            prev_emf_reg  <= '0;
        end
        else if (commit)
        begin
            prev_cur_reg  <= cur_reg;
            prev_volt_reg <= volt_reg;
            prev_emf_reg  <= emf_reg;
        end
    end

    assign motor_voltage = prev_volt_reg;
    assign motor_current = prev_cur_reg;
    assign back_emf      = prev_emf_reg;
    assign motor_rpm     = rpm_out_reg;
    assign wheel_rpm     = wheel_out_reg;

endmodule

[hw/rtl/dc_motor_back_emf_speed_estimator.sv]
// top level of the brushed dc motor back-emf speed estimator
// sample path: the sample beat is registered at the wait step, then the microprogram
//   runs eight products through the one shared 32x32 multiplier and the commit step
//   fills the output slot, holding while it is full; a new sample is taken only at the wait step
// reset: registers return to defaults, current/voltage/back-emf history clears to zero,
//   the sequencer returns to the wait step and no result is pending
module dc_motor_back_emf_speed_estimator #(
    parameter int ADC_BITS  = dcbemf_pkg::ADC_BITS_DEF,
    parameter int FRAC_BITS = dcbemf_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dcbemf_in_if.sink   sample,
    dcbemf_out_if.source result,
    dcbemf_cfg_if.sink  cfg
);

    // microprogram sequencer
    logic [dcbemf_pkg::STEP_W-1:0] step_reg;
    logic [dcbemf_pkg::STEP_W-1:0] step_next;
    dcbemf_pkg::ucode_t            uc;

    // result handshake
    logic out_valid_reg;
    logic out_valid_next;
    logic sample_beat;
    logic commit_ok;
    logic commit;

    // configuration registers
    dcbemf_pkg::cfg_bank_t cfg_regs_reg;

    // current control word straight from the rom
    assign uc = dcbemf_pkg::ucode(step_reg);

    // a sample is only taken in the wait step
    assign sample.ready = (uc.seq == dcbemf_pkg::SEQ_WAIT_IN);
    assign sample_beat  = sample.valid && sample.ready;

    // results move to the output slot once it is empty or being drained
    assign commit_ok = !out_valid_reg || result.ready;
    assign commit    = (uc.seq == dcbemf_pkg::SEQ_COMMIT) && commit_ok;

    // step counter with conditional jumps
    always_comb
    begin
        unique case (uc.seq)
            dcbemf_pkg::SEQ_WAIT_IN:
                step_next = sample_beat ? step_reg + 1'b1 : step_reg;
            dcbemf_pkg::SEQ_COMMIT:
                step_next = commit_ok ? uc.target : step_reg;
            dcbemf_pkg::SEQ_JUMP:
                step_next = uc.target;
            default:
                step_next = step_reg + 1'b1;
        endcase
    end

    // output slot: loaded at commit, cleared when the consumer takes the beat
    always_comb
    begin
        if (commit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= dcbemf_pkg::STEP_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid = out_valid_reg;

    // configuration writes, always accepted; unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_regs_reg <= dcbemf_pkg::CFG_RESET;
        else if (cfg.valid && (cfg.index < dcbemf_pkg::REG_IDX_W'(dcbemf_pkg::NUM_REGS)))
            cfg_regs_reg[cfg.index] <= cfg.data;
    end

    // arithmetic datapath under control of the microword
    dcbemf_datapath #(
        .ADC_BITS  (ADC_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (uc),
        .load          (sample_beat),
        .commit        (commit),
        .link_adc      (sample.link_adc),
        .pwm_duty      (sample.pwm_duty),
        .current_adc   (sample.current_adc),
        .cfg_regs      (cfg_regs_reg),
        .motor_voltage (result.motor_voltage),
        .motor_current (result.motor_current),
        .back_emf      (result.back_emf),
        .motor_rpm     (result.motor_rpm),
        .wheel_rpm     (result.wheel_rpm)
    );

endmodule
